// ===== hdl/ssr_pkg.sv =====
// Shared types, constants and helpers for the stream search-and-replace block.
package ssr_pkg;

    localparam int MAX_PATTERN_LEN     = 8;
    localparam int MAX_REPLACEMENT_LEN = 8;
    localparam int QUEUE_DEPTH         = 4;
    localparam int QUEUE_AW            = $clog2(QUEUE_DEPTH);
    localparam int LEN_W               = 4;
    localparam int CFG_DATA_W          = 64;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } cfg_idx_t;

    // Command kinds passed from front to back.
    typedef enum logic {
        CMD_BYTE    = 1'b0,
        CMD_REPLACE = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic       last;
    } cmd_t;

    typedef enum logic {
        FRONT_IDLE = 1'b0,
        FRONT_EVAL = 1'b1
    } front_state_t;

    // Saturate a length register into 1..maxlen.
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                   input logic [LEN_W-1:0] maxlen);
        logic [LEN_W-1:0] r;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (v > maxlen) begin
            r = maxlen;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== hdl/ssr_queue.sv =====
// Small command FIFO between the classifying front and the emitting back.
module ssr_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ssr_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output ssr_pkg::cmd_t pop_data,
    output logic          empty
);

    ssr_pkg::cmd_t                  mem_reg [ssr_pkg::QUEUE_DEPTH];
    logic [ssr_pkg::QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ssr_pkg::QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ssr_pkg::QUEUE_AW:0]     count_reg, count_next;
    logic                           do_push, do_pop;

    assign full     = (count_reg == (ssr_pkg::QUEUE_AW+1)'(ssr_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/ssr_front.sv =====
// Front end: takes text words, keeps the match window, queues byte/replace commands.
module ssr_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_text_byte,
    input  logic                               s_final_byte,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]     pattern_bytes,
    input  logic [ssr_pkg::LEN_W-1:0]          pattern_length,
    input  logic                               pattern_clear,
    output logic                               push,
    output ssr_pkg::cmd_t                      push_data,
    input  logic                               q_full
);

    ssr_pkg::front_state_t state_reg, state_next;
    logic [7:0]            win_reg  [ssr_pkg::MAX_PATTERN_LEN];
    logic [7:0]            win_next [ssr_pkg::MAX_PATTERN_LEN];
    logic [ssr_pkg::LEN_W-1:0] fill_reg, fill_next;
    logic                  last_reg, last_next;

    logic [ssr_pkg::LEN_W-1:0] plen;
    logic [2:0]                app_idx;
    logic                      prefix, match;
    logic [ssr_pkg::MAX_PATTERN_LEN-1:0] byte_ok;

    assign plen = ssr_pkg::clamp_len(pattern_length,
                                     ssr_pkg::LEN_W'(ssr_pkg::MAX_PATTERN_LEN));
    // a full window (never reached in practice) overwrites its top slot
    assign app_idx = (fill_reg >= ssr_pkg::LEN_W'(ssr_pkg::MAX_PATTERN_LEN)) ?
                     3'(ssr_pkg::MAX_PATTERN_LEN - 1) : fill_reg[2:0];

    always_comb begin
        for (int i = 0; i < ssr_pkg::MAX_PATTERN_LEN; i++) begin
            byte_ok[i] = (ssr_pkg::LEN_W'(i) >= fill_reg) ||
                         (win_reg[i] == pattern_bytes[8*i +: 8]);
        end
    end

    assign prefix = (&byte_ok) && (fill_reg <= plen);
    assign match  = prefix && (fill_reg == plen);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ssr_pkg::FRONT_IDLE: begin
                if (s_valid) begin
                    state_next = ssr_pkg::FRONT_EVAL;
                end
            end
            ssr_pkg::FRONT_EVAL: begin
                if (match) begin
                    if (!q_full) begin
                        state_next = ssr_pkg::FRONT_IDLE;
                    end
                end else if (last_reg) begin
                    if (!q_full && fill_reg == ssr_pkg::LEN_W'(1)) begin
                        state_next = ssr_pkg::FRONT_IDLE;
                    end
                end else if (prefix) begin
                    state_next = ssr_pkg::FRONT_IDLE;
                end
            end
            default: state_next = ssr_pkg::FRONT_IDLE;
        endcase
    end

    // outputs and window datapath
    always_comb begin
        s_ready   = 1'b0;
        push      = 1'b0;
        push_data = '{kind: ssr_pkg::CMD_BYTE, data: win_reg[0], last: 1'b0};
        win_next  = win_reg;
        fill_next = fill_reg;
        last_next = last_reg;
        case (state_reg)
            ssr_pkg::FRONT_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    win_next[app_idx] = s_text_byte;
                    fill_next         = ssr_pkg::LEN_W'(app_idx) + 1'b1;
                    last_next         = s_final_byte;
                end else if (pattern_clear) begin
                    fill_next = '0;
                end
            end
            ssr_pkg::FRONT_EVAL: begin
                if (match) begin
                    push      = !q_full;
                    push_data = '{kind: ssr_pkg::CMD_REPLACE, data: win_reg[0],
                                  last: last_reg};
                    if (!q_full) begin
                        fill_next = '0;
                    end
                end else if (last_reg || !prefix) begin
                    // drop (or flush) the oldest window byte
                    push      = !q_full;
                    push_data = '{kind: ssr_pkg::CMD_BYTE, data: win_reg[0],
                                  last: last_reg && (fill_reg == ssr_pkg::LEN_W'(1))};
                    if (!q_full) begin
                        for (int i = 0; i < ssr_pkg::MAX_PATTERN_LEN - 1; i++) begin
                            win_next[i] = win_reg[i+1];
                        end
                        fill_next = fill_reg - 1'b1;
                    end
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ssr_pkg::FRONT_IDLE;
            fill_reg  <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            last_reg  <= last_next;
        end
    end

endmodule

// ===== hdl/ssr_back.sv =====
// Back end: pops commands and emits result words, expanding replacements byte by byte.
module ssr_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_empty,
    input  ssr_pkg::cmd_t                  q_data,
    output logic                           pop,
    input  logic [ssr_pkg::CFG_DATA_W-1:0] replacement_bytes,
    input  logic [ssr_pkg::LEN_W-1:0]      replacement_length,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_result_byte,
    output logic                           m_result_final
);

    ssr_pkg::cmd_t cur_reg, cur_next;
    logic          cur_valid_reg, cur_valid_next;
    logic [2:0]    idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_final_reg, out_final_next;

    logic [ssr_pkg::LEN_W-1:0] rlen;
    logic [2:0]                rlen_m1;
    logic                      load_ok, last_beat, beat;

    assign rlen    = ssr_pkg::clamp_len(replacement_length,
                                        ssr_pkg::LEN_W'(ssr_pkg::MAX_REPLACEMENT_LEN));
    assign rlen_m1 = 3'(rlen - 1'b1);

    assign load_ok   = !out_valid_reg || m_ready;
    assign last_beat = (cur_reg.kind == ssr_pkg::CMD_BYTE) || (idx_reg == rlen_m1);
    assign beat      = cur_valid_reg && load_ok;
    assign pop       = !q_empty && (!cur_valid_reg || (beat && last_beat));

    always_comb begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_final_next = out_final_reg;
        if (beat) begin
            out_valid_next = 1'b1;
            if (cur_reg.kind == ssr_pkg::CMD_BYTE) begin
                out_byte_next  = cur_reg.data;
                out_final_next = cur_reg.last;
            end else begin
                out_byte_next  = replacement_bytes[{idx_reg, 3'b000} +: 8];
                out_final_next = cur_reg.last && (idx_reg == rlen_m1);
            end
        end else if (load_ok) begin
            out_valid_next = 1'b0;
        end
    end

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (beat) begin
            idx_next = last_beat ? 3'd0 : idx_reg + 1'b1;
            if (last_beat) begin
                cur_valid_next = 1'b0;
            end
        end
        if (pop) begin
            cur_next       = q_data;
            cur_valid_next = 1'b1;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_byte  = out_byte_reg;
    assign m_result_final = out_final_reg;

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        out_byte_reg  <= out_byte_next;
        out_final_reg <= out_final_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/stream_search_replace_core.sv =====
// Top level of the streaming search-and-replace core: config registers, front, queue, back.
// Path: an input word passes classify and queue write, command load and the output register
//   before m_valid rises for its first result word.
// Throughput: the front takes a word only while idle, then slides the match window one byte per
//   cycle while the queue is not full; the back emits one result word per cycle while m_ready
//   allows it, so a replacement gives replacement_length result words.
// Reset (aresetn low, synchronous): window empty, queue and output cleared, pattern 0 of
//   length 1, replacement 0 of length 1.
module stream_search_replace_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input text stream
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_text_byte,
    input  logic                           s_final_byte,
    // rewritten text stream
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_result_byte,
    output logic                           m_result_final,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers
    logic [ssr_pkg::CFG_DATA_W-1:0] pattern_bytes_reg, pattern_bytes_next;
    logic [ssr_pkg::LEN_W-1:0]      pattern_length_reg, pattern_length_next;
    logic [ssr_pkg::CFG_DATA_W-1:0] replacement_bytes_reg, replacement_bytes_next;
    logic [ssr_pkg::LEN_W-1:0]      replacement_length_reg, replacement_length_next;
    logic                           pattern_clear;

    // Front <-> queue <-> back
    logic          q_push, q_full, q_pop, q_empty;
    ssr_pkg::cmd_t q_push_data, q_pop_data;

    always_comb begin
        pattern_bytes_next      = pattern_bytes_reg;
        pattern_length_next     = pattern_length_reg;
        replacement_bytes_next  = replacement_bytes_reg;
        replacement_length_next = replacement_length_reg;
        pattern_clear           = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_index)
                ssr_pkg::CFG_PATTERN_BYTES: begin
                    pattern_bytes_next = cfg_wdata;
                    pattern_clear      = 1'b1;   // held window no longer valid
                end
                ssr_pkg::CFG_PATTERN_LENGTH: begin
                    pattern_length_next = cfg_wdata[ssr_pkg::LEN_W-1:0];
                    pattern_clear       = 1'b1;
                end
                ssr_pkg::CFG_REPLACEMENT_BYTES: begin
                    replacement_bytes_next = cfg_wdata;
                end
                ssr_pkg::CFG_REPLACEMENT_LENGTH: begin
                    replacement_length_next = cfg_wdata[ssr_pkg::LEN_W-1:0];
                end
                default: begin
                    pattern_clear = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= ssr_pkg::LEN_W'(1);
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= ssr_pkg::LEN_W'(1);
        end else begin
            pattern_bytes_reg      <= pattern_bytes_next;
            pattern_length_reg     <= pattern_length_next;
            replacement_bytes_reg  <= replacement_bytes_next;
            replacement_length_reg <= replacement_length_next;
        end
    end

    // Front: appends each word to the window, then per cycle either queues a replace, drops/flushes
    // the oldest byte, waits while the queue is full, or goes back to idle.
    ssr_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .s_final_byte   (s_final_byte),
        .pattern_bytes  (pattern_bytes_reg),
        .pattern_length (pattern_length_reg),
        .pattern_clear  (pattern_clear),
        .push           (q_push),
        .push_data      (q_push_data),
        .q_full         (q_full)
    );

    // Decoupling queue: lets the front keep classifying while the back stalls.
    ssr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // Back: one result word per cycle into the output register while it is free and commands wait.
    ssr_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_empty            (q_empty),
        .q_data             (q_pop_data),
        .pop                (q_pop),
        .replacement_bytes  (replacement_bytes_reg),
        .replacement_length (replacement_length_reg),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_result_byte      (m_result_byte),
        .m_result_final     (m_result_final)
    );

endmodule
